// ----- design/lud_pkg.sv -----
// shared types, constants and fixed-point helpers for the lens undistortion core
package lud_pkg;

	// number of scale refinement passes after the first polynomial
	localparam int REFINE_STEPS = 9;

	// internal values: signed, 24 fraction bits, saturated to +-(2^31 - 1)
	localparam int FRAC  = 24;
	localparam int Q_W   = 32;
	localparam int MAG_W = Q_W - 1;

	// divider: dividend magnitude, divisor magnitude, quotient bits before saturation
	localparam int NUM_W = 55;
	localparam int DEN_W = MAG_W;
	localparam int QUO_W = MAG_W;
	localparam int CMP_W = DEN_W + QUO_W;

	// interface widths
	localparam int PIX_W   = 16;
	localparam int COEF_W  = 24;
	localparam int COEF_SH = 4;
	localparam int OUT_W   = 20;
	localparam int OUT_FRAC = 16;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;

	// latencies in register stages
	localparam int DIV_LAT    = QUO_W + 1;
	localparam int POLY_LAT   = 6;
	localparam int REFINE_LAT = 1 + DIV_LAT + POLY_LAT;
	localparam int CORE_LAT   = 2 * DIV_LAT + 2 + POLY_LAT + REFINE_STEPS * REFINE_LAT + 1;

	typedef logic signed [Q_W-1:0]    q_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [NUM_W-1:0]         num_t;
	typedef logic [DEN_W-1:0]         den_t;
	typedef logic [PIX_W-1:0]         pix_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [OUT_W-1:0]  out_t;
	typedef logic [CFG_W-1:0]         cfg_data_t;
	typedef logic [IDX_W-1:0]         cfg_idx_t;

	// values that ride along with an item through the scale loop
	typedef struct packed {
		q_t dx;
		q_t dy;
		q_t ps;
	} side_t;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_FOCAL_X  = 3'd0,
		REG_FOCAL_Y  = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_RADIAL_K1 = 3'd4,
		REG_RADIAL_K2 = 3'd5,
		REG_RADIAL_K3 = 3'd6
	} reg_idx_t;

	localparam mag_t MAG_MAX = '1;
	localparam q_t   SAT_MAX = q_t'({1'b0, MAG_MAX});
	localparam q_t   ONE_Q   = q_t'(64'd1 << FRAC);
	localparam q_t   OUT_MAX = q_t'(524287);
	localparam q_t   OUT_MIN = -q_t'(524288);

	localparam int PT_W = 2 * MAG_W - FRAC;
	localparam logic signed [Q_W:0] SUM_MAX = {1'b0, SAT_MAX};
	localparam logic signed [Q_W:0] SUM_MIN = -SUM_MAX;

	// magnitude of an in-range value
	function automatic mag_t mag_of(q_t v);
		q_t n;
		n = -v;
		return v[Q_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	// product with truncation toward zero and saturation
	function automatic q_t mul_q(q_t a, q_t b);
		logic [2*MAG_W-1:0] p;
		logic [PT_W-1:0]    t;
		mag_t               m;
		p = {{MAG_W{1'b0}}, mag_of(a)} * {{MAG_W{1'b0}}, mag_of(b)};
		t = p[2*MAG_W-1:FRAC];
		m = (t > PT_W'(MAG_MAX)) ? MAG_MAX : t[MAG_W-1:0];
		return (a[Q_W-1] ^ b[Q_W-1]) ? -q_t'({1'b0, m}) : q_t'({1'b0, m});
	endfunction

	// saturating sum
	function automatic q_t add_sat(q_t a, q_t b);
		logic signed [Q_W:0] s;
		s = {a[Q_W-1], a} + {b[Q_W-1], b};
		if (s > SUM_MAX)
			s = SUM_MAX;
		else if (s < SUM_MIN)
			s = SUM_MIN;
		return s[Q_W-1:0];
	endfunction

	// coefficient widened from 20 to 24 fraction bits
	function automatic q_t coef_q(coef_t c);
		return q_t'({{(Q_W-COEF_W-COEF_SH){c[COEF_W-1]}}, c, {COEF_SH{1'b0}}});
	endfunction

endpackage

// ----- design/lud_div.sv -----
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module lud_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  lud_pkg::num_t   num,
	input  lud_pkg::den_t   den,
	input  logic            neg,
	input  lud_pkg::side_t  side_in,
	output logic            out_valid,
	output lud_pkg::q_t     quo,
	output lud_pkg::side_t  side_out
);
	import lud_pkg::*;

	logic             vld_s  [0:QUO_W];
	num_t             rem_s  [0:QUO_W];
	den_t             den_s  [0:QUO_W];
	logic [QUO_W-1:0] quo_s  [0:QUO_W];
	logic             neg_s  [0:QUO_W];
	logic             ovf_s  [0:QUO_W];
	side_t            side_s [0:QUO_W];

	mag_t qmag;

	// input stage: quotient of 2^31 or more saturates, a zero divisor included
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= num;
		den_s[0]  <= den;
		quo_s[0]  <= '0;
		neg_s[0]  <= neg;
		ovf_s[0]  <= {{(CMP_W-NUM_W){1'b0}}, num} >= {den, {QUO_W{1'b0}}};
		side_s[0] <= side_in;
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int B = QUO_W - 1 - k;
		logic [CMP_W-1:0] shifted;
		logic [CMP_W-1:0] rem_w;
		logic [CMP_W-1:0] diff;
		logic             take;
		logic [QUO_W-1:0] quo_n;

		always_comb begin
			shifted = {{QUO_W{1'b0}}, den_s[k]} << B;
			rem_w   = {{(CMP_W-NUM_W){1'b0}}, rem_s[k]};
			diff    = rem_w - shifted;
			take    = rem_w >= shifted;
			quo_n    = quo_s[k];
			quo_n[B] = take;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= take ? diff[NUM_W-1:0] : rem_s[k];
			den_s[k+1]  <= den_s[k];
			quo_s[k+1]  <= quo_n;
			neg_s[k+1]  <= neg_s[k];
			ovf_s[k+1]  <= ovf_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	// saturate and apply the sign
	assign qmag      = ovf_s[QUO_W] ? MAG_MAX : quo_s[QUO_W];
	assign quo       = neg_s[QUO_W] ? -q_t'({1'b0, qmag}) : q_t'({1'b0, qmag});
	assign out_valid = vld_s[QUO_W];
	assign side_out  = side_s[QUO_W];

endmodule

// ----- design/lud_poly.sv -----
// pipelined radial polynomial 1 + k1*x + k2*x^2 + k3*x^3 in Horner form
module lud_poly (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  lud_pkg::q_t     x_in,
	input  lud_pkg::side_t  side_in,
	input  lud_pkg::coef_t  radial_k1,
	input  lud_pkg::coef_t  radial_k2,
	input  lud_pkg::coef_t  radial_k3,
	output logic            out_valid,
	output lud_pkg::q_t     val_out,
	output lud_pkg::side_t  side_out
);
	import lud_pkg::*;

	logic  vld_s  [0:POLY_LAT];
	q_t    val_s  [0:POLY_LAT];
	q_t    x_s    [0:POLY_LAT];
	side_t side_s [0:POLY_LAT];
	q_t    addend [0:2];

	assign vld_s[0]  = in_valid;
	assign val_s[0]  = coef_q(radial_k3);
	assign x_s[0]    = x_in;
	assign side_s[0] = side_in;

	assign addend[0] = coef_q(radial_k2);
	assign addend[1] = coef_q(radial_k1);
	assign addend[2] = ONE_Q;

	// each Horner step: multiply stage, then add stage
	for (genvar j = 0; j < 3; j++) begin : g_horner
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[2*j+1] <= 1'b0;
				vld_s[2*j+2] <= 1'b0;
			end else begin
				vld_s[2*j+1] <= vld_s[2*j];
				vld_s[2*j+2] <= vld_s[2*j+1];
			end
		end

		always_ff @(posedge clk) begin
			val_s[2*j+1]  <= mul_q(val_s[2*j], x_s[2*j]);
			x_s[2*j+1]    <= x_s[2*j];
			side_s[2*j+1] <= side_s[2*j];
			val_s[2*j+2]  <= add_sat(val_s[2*j+1], addend[j]);
			x_s[2*j+2]    <= x_s[2*j+1];
			side_s[2*j+2] <= side_s[2*j+1];
		end
	end

	assign out_valid = vld_s[POLY_LAT];
	assign val_out   = val_s[POLY_LAT];
	assign side_out  = side_s[POLY_LAT];

endmodule

// ----- design/lud_refine.sv -----
// one refinement pass: qd = ps / qs^2, then qs = poly(qd)
module lud_refine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  lud_pkg::q_t     qs_in,
	input  lud_pkg::side_t  side_in,
	input  lud_pkg::coef_t  radial_k1,
	input  lud_pkg::coef_t  radial_k2,
	input  lud_pkg::coef_t  radial_k3,
	output logic            out_valid,
	output lud_pkg::q_t     qs_out,
	output lud_pkg::side_t  side_out
);
	import lud_pkg::*;

	logic  vld_s1;
	q_t    sq_s1;
	side_t side_s1;

	logic  div_vld;
	q_t    div_quo;
	side_t div_side;

	// square of the current scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1   <= mul_q(qs_in, qs_in);
		side_s1 <= side_in;
	end

	// ps and qs^2 are never negative; a zero square saturates the quotient
	lud_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.num      (num_t'({mag_of(side_s1.ps), {FRAC{1'b0}}})),
		.den      (mag_of(sq_s1)),
		.neg      (1'b0),
		.side_in  (side_s1),
		.out_valid(div_vld),
		.quo      (div_quo),
		.side_out (div_side)
	);

	lud_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_vld),
		.x_in     (div_quo),
		.side_in  (div_side),
		.radial_k1(radial_k1),
		.radial_k2(radial_k2),
		.radial_k3(radial_k3),
		.out_valid(out_valid),
		.val_out  (qs_out),
		.side_out (side_out)
	);

endmodule

// ----- design/lens_undistort_iterative_core.sv -----
// top level of the iterative radial lens undistortion core
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------
//  pixel in  | start, busy        | pixel_x, pixel_y (Q10.6)
//  result    | done (one cycle)   | norm_x, norm_y (signed Q3.16)
//  config    | cfg_we             | cfg_index, cfg_data
//
// one item enters every clock; busy is always low
// every item gives its result on done; the delay from taking it is set by the
// eleven 32-stage dividers in series (normalize, nine refinement quotients,
// final scale) plus the polynomial and multiply stages
// reset clears all stage valid bits and loads the default lens registers
// the receiver cannot stall, so nothing in the pipeline ever waits
module lens_undistort_iterative_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  lud_pkg::pix_t        pixel_x,
	input  lud_pkg::pix_t        pixel_y,
	output logic                 done,
	output lud_pkg::out_t        norm_x,
	output lud_pkg::out_t        norm_y,
	input  logic                 cfg_we,
	input  lud_pkg::cfg_idx_t    cfg_index,
	input  lud_pkg::cfg_data_t   cfg_data
);
	import lud_pkg::*;

	pix_t  focal_x_q, focal_y_q, center_x_q, center_y_q;
	coef_t radial_k1_q, radial_k2_q, radial_k3_q;

	logic              accept;
	logic signed [PIX_W:0] diff_x, diff_y;
	logic [PIX_W-1:0]  amag_x, amag_y;
	pix_t              fx_eff, fy_eff;

	logic  dvx_vld, dvy_vld;
	q_t    dx_div, dy_div;

	logic  vld_s1, vld_s2;
	q_t    dxx_s1, dyy_s1, dx_s1, dy_s1;
	q_t    ps_s2;
	side_t side_s2;

	logic  chain_vld [0:REFINE_STEPS];
	q_t    chain_qs  [0:REFINE_STEPS];
	side_t chain_sd  [0:REFINE_STEPS];

	side_t fin_sd;
	q_t    fin_qs;
	mag_t  qs_mag;
	logic  ox_vld, oy_vld;
	q_t    ox_quo, oy_quo;

	logic  done_q;
	out_t  norm_x_q, norm_y_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q   <= pix_t'(23360);
			focal_y_q   <= pix_t'(23360);
			center_x_q  <= pix_t'(16384);
			center_y_q  <= pix_t'(13568);
			radial_k1_q <= '0;
			radial_k2_q <= '0;
			radial_k3_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL_X:   focal_x_q   <= cfg_data[PIX_W-1:0];
				REG_FOCAL_Y:   focal_y_q   <= cfg_data[PIX_W-1:0];
				REG_CENTER_X:  center_x_q  <= cfg_data[PIX_W-1:0];
				REG_CENTER_Y:  center_y_q  <= cfg_data[PIX_W-1:0];
				REG_RADIAL_K1: radial_k1_q <= cfg_data[COEF_W-1:0];
				REG_RADIAL_K2: radial_k2_q <= cfg_data[COEF_W-1:0];
				REG_RADIAL_K3: radial_k3_q <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// offset from the principal point; a zero focal length counts as one
	always_comb begin
		diff_x = $signed({1'b0, pixel_x}) - $signed({1'b0, center_x_q});
		diff_y = $signed({1'b0, pixel_y}) - $signed({1'b0, center_y_q});
		amag_x = diff_x[PIX_W] ? PIX_W'(-diff_x) : diff_x[PIX_W-1:0];
		amag_y = diff_y[PIX_W] ? PIX_W'(-diff_y) : diff_y[PIX_W-1:0];
		fx_eff = (focal_x_q == '0) ? pix_t'(1) : focal_x_q;
		fy_eff = (focal_y_q == '0) ? pix_t'(1) : focal_y_q;
	end

	// normalize both coordinates
	lud_div u_div_dx (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.num      (num_t'({amag_x, {FRAC{1'b0}}})),
		.den      (den_t'(fx_eff)),
		.neg      (diff_x[PIX_W]),
		.side_in  ('0),
		.out_valid(dvx_vld),
		.quo      (dx_div),
		.side_out ()
	);

	lud_div u_div_dy (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.num      (num_t'({amag_y, {FRAC{1'b0}}})),
		.den      (den_t'(fy_eff)),
		.neg      (diff_y[PIX_W]),
		.side_in  ('0),
		.out_valid(dvy_vld),
		.quo      (dy_div),
		.side_out ()
	);

	// squared radius: square stage, then sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= dvx_vld && dvy_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dxx_s1     <= mul_q(dx_div, dx_div);
		dyy_s1     <= mul_q(dy_div, dy_div);
		dx_s1      <= dx_div;
		dy_s1      <= dy_div;
		ps_s2      <= add_sat(dxx_s1, dyy_s1);
		side_s2.dx <= dx_s1;
		side_s2.dy <= dy_s1;
		side_s2.ps <= add_sat(dxx_s1, dyy_s1);
	end

	// first scale estimate
	lud_poly u_poly0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.x_in     (ps_s2),
		.side_in  (side_s2),
		.radial_k1(radial_k1_q),
		.radial_k2(radial_k2_q),
		.radial_k3(radial_k3_q),
		.out_valid(chain_vld[0]),
		.val_out  (chain_qs[0]),
		.side_out (chain_sd[0])
	);

	// chain of refinement passes
	for (genvar i = 0; i < REFINE_STEPS; i++) begin : g_refine
		lud_refine u_refine (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_vld[i]),
			.qs_in    (chain_qs[i]),
			.side_in  (chain_sd[i]),
			.radial_k1(radial_k1_q),
			.radial_k2(radial_k2_q),
			.radial_k3(radial_k3_q),
			.out_valid(chain_vld[i+1]),
			.qs_out   (chain_qs[i+1]),
			.side_out (chain_sd[i+1])
		);
	end

	// final scale: a zero offset divides by one so it stays zero
	assign fin_sd = chain_sd[REFINE_STEPS];
	assign fin_qs = chain_qs[REFINE_STEPS];
	assign qs_mag = mag_of(fin_qs);

	lud_div u_div_ox (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_vld[REFINE_STEPS]),
		.num      (num_t'({mag_of(fin_sd.dx), {OUT_FRAC{1'b0}}})),
		.den      ((fin_sd.dx == '0) ? den_t'(1) : qs_mag),
		.neg      (fin_sd.dx[Q_W-1] ^ fin_qs[Q_W-1]),
		.side_in  ('0),
		.out_valid(ox_vld),
		.quo      (ox_quo),
		.side_out ()
	);

	lud_div u_div_oy (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_vld[REFINE_STEPS]),
		.num      (num_t'({mag_of(fin_sd.dy), {OUT_FRAC{1'b0}}})),
		.den      ((fin_sd.dy == '0) ? den_t'(1) : qs_mag),
		.neg      (fin_sd.dy[Q_W-1] ^ fin_qs[Q_W-1]),
		.side_in  ('0),
		.out_valid(oy_vld),
		.quo      (oy_quo),
		.side_out ()
	);

	// clamp to the output range and register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ox_vld && oy_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ox_quo > OUT_MAX)
			norm_x_q <= OUT_MAX[OUT_W-1:0];
		else if (ox_quo < OUT_MIN)
			norm_x_q <= OUT_MIN[OUT_W-1:0];
		else
			norm_x_q <= ox_quo[OUT_W-1:0];
		if (oy_quo > OUT_MAX)
			norm_y_q <= OUT_MAX[OUT_W-1:0];
		else if (oy_quo < OUT_MIN)
			norm_y_q <= OUT_MIN[OUT_W-1:0];
		else
			norm_y_q <= oy_quo[OUT_W-1:0];
	end

	assign done   = done_q;
	assign norm_x = norm_x_q;
	assign norm_y = norm_y_q;

`ifndef ASSERT_OFF
	// every accepted item comes out after the fixed latency
	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##CORE_LAT done)
		else $error("accepted item did not produce a result on time");

	// no result without an item taken the fixed latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, CORE_LAT))
		else $error("result without a matching accepted item");

	// both lanes of the normalize dividers stay in step
	a_lanes_align: assert property (@(posedge clk) disable iff (!arst_n)
		dvx_vld == dvy_vld)
		else $error("normalize divider lanes out of step");
`endif

endmodule

// ----- tb/lens_undistort_iterative_core_tb.sv -----
// testbench for the iterative lens undistortion core: directed and random pixels checked against a fixed-point model
module lens_undistort_iterative_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lud_pkg::*;

	localparam int N_REFINE = 9;
	localparam longint LIM = 64'sd2147483647;
	localparam longint NORM_HI = 64'sd524287;
	localparam longint NORM_LO = -64'sd524288;
	localparam int DRAIN = 500;

	// lens settings as the predictor sees them
	typedef struct {
		longint fx, fy, cx, cy, k1, k2, k3;
	} lens_t;

	typedef struct {
		logic signed [19:0] nx;
		logic signed [19:0] ny;
	} norm_pair_t;

	// undistortion predictor and queue of pending coordinates
	class undistort_scoreboard;
		lens_t lens;
		norm_pair_t pending[$];
		int errors;

		function void reset_lens();
			lens.fx = 23360; lens.fy = 23360; lens.cx = 16384; lens.cy = 13568;
			lens.k1 = 0; lens.k2 = 0; lens.k3 = 0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [23:0] val);
			case (idx)
				REG_FOCAL_X: lens.fx = val[15:0];
				REG_FOCAL_Y: lens.fy = val[15:0];
				REG_CENTER_X: lens.cx = val[15:0];
				REG_CENTER_Y: lens.cy = val[15:0];
				REG_RADIAL_K1: lens.k1 = longint'($signed(val)) * 16;
				REG_RADIAL_K2: lens.k2 = longint'($signed(val)) * 16;
				REG_RADIAL_K3: lens.k3 = longint'($signed(val)) * 16;
				default: ;
			endcase
		endfunction

		function longint sat(longint v);
			return v > LIM ? LIM : (v < -LIM ? -LIM : v);
		endfunction

		function longint absv(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint qmul(longint a, longint b);
			longint p;
			p = (absv(a) * absv(b)) >>> 24;
			return sat(((a < 0) != (b < 0)) ? -p : p);
		endfunction

		function longint qdiv(longint n, longint d, int sh);
			logic [63:0] q;
			q = (64'(absv(n)) << sh) / 64'(absv(d));
			if (q > 64'(LIM)) q = 64'(LIM);
			return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
		endfunction

		function longint poly(longint p);
			longint a;
			a = lens.k3;
			a = sat(qmul(a, p) + lens.k2);
			a = sat(qmul(a, p) + lens.k1);
			return sat(qmul(a, p) + (64'sd1 << 24));
		endfunction

		function logic signed [19:0] scale_out(longint d, longint qs);
			longint r;
			if (qs == 0) r = d > 0 ? NORM_HI : (d < 0 ? NORM_LO : 0);
			else begin
				r = qdiv(d, qs, 16);
				r = r > NORM_HI ? NORM_HI : (r < NORM_LO ? NORM_LO : r);
			end
			return r[19:0];
		endfunction

		function void note_pixel(logic [15:0] px, logic [15:0] py);
			longint fx, fy, dx, dy, ps, qs, q2, qd;
			norm_pair_t e;
			fx = lens.fx == 0 ? 1 : lens.fx;
			fy = lens.fy == 0 ? 1 : lens.fy;
			dx = qdiv(longint'(px) - lens.cx, fx, 24);
			dy = qdiv(longint'(py) - lens.cy, fy, 24);
			ps = sat(qmul(dx, dx) + qmul(dy, dy));
			qs = poly(ps);
			for (int i = 0; i < N_REFINE; i++) begin
				q2 = qmul(qs, qs);
				qd = q2 == 0 ? LIM : qdiv(ps, q2, 24);
				qs = poly(qd);
			end
			e.nx = scale_out(dx, qs);
			e.ny = scale_out(dy, qs);
			pending.insert(pending.size(), e);
		endfunction

		function void check_result(logic signed [19:0] nx, logic signed [19:0] ny);
			norm_pair_t e;
			if (pending.size() == 0) begin
				$error("result with nothing pending: norm_x %0d norm_y %0d", nx, ny);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (nx !== e.nx) begin
				$error("norm_x expected %0d actual %0d", e.nx, nx);
				errors++;
			end
			if (ny !== e.ny) begin
				$error("norm_y expected %0d actual %0d", e.ny, ny);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	pix_t pixel_x = '0;
	pix_t pixel_y = '0;
	logic done;
	out_t norm_x, norm_y;
	logic cfg_we = 0;
	cfg_idx_t cfg_index = '0;
	cfg_data_t cfg_data = '0;

	undistort_scoreboard sb;
	int gap_pct = 37;

	lens_undistort_iterative_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .done(done),
		.norm_x(norm_x), .norm_y(norm_y),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(norm_x, norm_y);
	end

	// one pixel item, with a random idle gap first; start stays high for back-to-back items
	task automatic send_pixel(logic [15:0] px, logic [15:0] py);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			pixel_x <= 16'($urandom);
			pixel_y <= 16'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		pixel_x <= px;
		pixel_y <= py;
		do @(posedge clk); while (busy);
		sb.note_pixel(px, py);
	endtask

	// idle until every pending item has come back, then let the pipe drain
	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 1'b0;
	endtask

	task automatic set_lens(logic [15:0] fx, logic [15:0] fy, logic [15:0] cx,
		logic [15:0] cy, logic [23:0] k1, logic [23:0] k2, logic [23:0] k3);
		write_reg(REG_FOCAL_X, {8'h0, fx});
		write_reg(REG_FOCAL_Y, {8'h0, fy});
		write_reg(REG_CENTER_X, {8'h0, cx});
		write_reg(REG_CENTER_Y, {8'h0, cy});
		write_reg(REG_RADIAL_K1, k1);
		write_reg(REG_RADIAL_K2, k2);
		write_reg(REG_RADIAL_K3, k3);
	endtask

	// random pixels, mostly near the center, some anywhere
	task automatic random_burst(int n);
		logic [15:0] px, py;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				px = 16'($urandom);
				py = 16'($urandom);
			end else begin
				px = 16'(sb.lens.cx + $urandom_range(8000) - 4000);
				py = 16'(sb.lens.cy + $urandom_range(8000) - 4000);
			end
			send_pixel(px, py);
		end
	endtask

	// run limit
	initial begin
		#50ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		sb = new();
		sb.reset_lens();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners, the center and two mixed points with the reset lens
		send_pixel(16'h0000, 16'h0000);
		send_pixel(16'hFFFF, 16'hFFFF);
		send_pixel(16'd16384, 16'd13568);
		send_pixel(16'h0000, 16'hFFFF);
		send_pixel(16'hFFFF, 16'h0000);
		send_pixel(16'h5555, 16'hAAAA);
		send_pixel(16'hAAAA, 16'h5555);
		wait_idle();

		// zero focal lengths, strong positive and negative distortion
		set_lens(16'd0, 16'd0, 16'd0, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send_pixel(16'hFFFF, 16'h0000);
		send_pixel(16'h0000, 16'hFFFF);
		send_pixel(16'h0001, 16'hFFFE);
		wait_idle();
		set_lens(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 24'h800000, 24'h800000, 24'h800000);
		send_pixel(16'h0000, 16'hFFFF);
		send_pixel(16'hFFFF, 16'h0000);
		send_pixel(16'h8000, 16'h8000);
		wait_idle();
		// qs driven to zero: k1 = -1, large radius
		set_lens(16'd64, 16'd64, 16'd16384, 16'd16384, 24'hF00000, 24'h0, 24'h0);
		send_pixel(16'd16448, 16'd16384);
		send_pixel(16'd16320, 16'd16384);
		send_pixel(16'd16384, 16'd16384);
		send_pixel(16'hFFFF, 16'h0000);
		wait_idle();
		// out-of-list register index is ignored
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= cfg_idx_t'(7);
		cfg_data <= 24'hFFFFFF;
		@(posedge clk);
		cfg_we <= 1'b0;

		// random phases with several lens settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_lens(16'd23360, 16'd23360, 16'd16384, 16'd13568,
					24'h01A000, 24'hFF8000, 24'h002000);
				1: set_lens(16'd640, 16'd700, 16'd16384, 16'd13568,
					24'hFE0000, 24'h008000, 24'hFFF000);
				2: set_lens(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
					16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
				3: set_lens(16'd1, 16'd1, 16'($urandom), 16'($urandom),
					24'h7FFFFF, 24'h800000, 24'h000001);
				default: set_lens(16'($urandom_range(30000, 200)), 16'($urandom_range(30000, 200)),
					16'($urandom), 16'($urandom), 24'($urandom_range(300000)) - 24'd150000,
					24'($urandom_range(200000)) - 24'd100000,
					24'($urandom_range(100000)) - 24'd50000);
			endcase
			gap_pct = (ph == 4) ? 0 : 37;
			random_burst(240);
			wait_idle();
		end
		gap_pct = 37;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ----- files.f -----
design/lud_pkg.sv
design/lud_div.sv
design/lud_poly.sv
design/lud_refine.sv
design/lens_undistort_iterative_core.sv
tb/lens_undistort_iterative_core_tb.sv
